>>> src/tpc_pkg.sv
// Shared types and constants for the triangle/plane crossing core.
`default_nettype none
package tpc_pkg;

  typedef enum logic [2:0] {
    CODE_NONE = 3'd0,
    CODE_V1   = 3'd1,
    CODE_V2   = 3'd2,
    CODE_V3   = 3'd3,
    CODE_E12  = 3'd4,
    CODE_E23  = 3'd5,
    CODE_E31  = 3'd6
  } code_t;

  typedef struct packed {
    logic  hit;
    code_t entry_code;
    code_t exit_code;
  } tpc_tag_t;

  localparam int EPS_BITS = 16;
  localparam logic [EPS_BITS-1:0] EPS_RESET = 16'd1;
  localparam int QDEPTH = 2;

endpackage
`default_nettype wire

>>> src/tpc_front.sv
// Front end: holds the tolerance register and sorts a triangle into its crossing case.
`default_nettype none
module tpc_front
  import tpc_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         eps_we,
  input  wire  [EPS_BITS-1:0]         eps_wdata,
  input  wire  signed [COORD_BITS-1:0] v1_x, v1_y, v1_z,
  input  wire  signed [COORD_BITS-1:0] v2_x, v2_y, v2_z,
  input  wire  signed [COORD_BITS-1:0] v3_x, v3_y, v3_z,
  output tpc_tag_t                    tag,
  output logic signed [COORD_BITS-1:0] seg_ax [2],
  output logic signed [COORD_BITS-1:0] seg_az [2],
  output logic signed [COORD_BITS-1:0] seg_bx [2],
  output logic signed [COORD_BITS-1:0] seg_bz [2],
  output logic signed [COORD_BITS-1:0] seg_ay [2],
  output logic signed [COORD_BITS:0]   seg_den [2],
  output logic                        seg_degen [2]
);

  localparam int W = COORD_BITS + 1;

  logic [EPS_BITS-1:0] plane_epsilon;
  logic signed [COORD_BITS-1:0] vx [3];
  logic signed [COORD_BITS-1:0] vy [3];
  logic signed [COORD_BITS-1:0] vz [3];
  logic [2:0] ypos, yneg, ynear;
  logic [1:0] ia [2];
  logic [1:0] ib [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_epsilon <= EPS_RESET;
    end else if (eps_we) begin
      plane_epsilon <= eps_wdata;
    end
  end

  assign vx[0] = v1_x; assign vy[0] = v1_y; assign vz[0] = v1_z;
  assign vx[1] = v2_x; assign vy[1] = v2_y; assign vz[1] = v2_z;
  assign vx[2] = v3_x; assign vy[2] = v3_y; assign vz[2] = v3_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      yneg[i]  = vy[i][COORD_BITS-1];
      ypos[i]  = !yneg[i] && (vy[i] != '0);
      // The tolerance is never negative, so any negative y is near.
      ynear[i] = yneg[i] ||
                 ({{EPS_BITS{1'b0}}, vy[i]} < {{COORD_BITS{1'b0}}, plane_epsilon});
    end
  end

  // Case selection; the first matching case wins.
  always_comb begin
    tag.hit        = 1'b1;
    tag.entry_code = CODE_NONE;
    tag.exit_code  = CODE_NONE;
    ia[0] = 2'd0; ib[0] = 2'd0; ia[1] = 2'd0; ib[1] = 2'd0;
    if (ypos[0] && yneg[1] && yneg[2]) begin
      ia[0] = 2'd0; ib[0] = 2'd1; ia[1] = 2'd0; ib[1] = 2'd2;
      tag.entry_code = CODE_E12; tag.exit_code = CODE_E31;
    end else if (yneg[0] && !yneg[1] && !yneg[2]) begin
      ia[0] = 2'd0; ib[0] = 2'd2; ia[1] = 2'd0; ib[1] = 2'd1;
      tag.entry_code = ynear[2] ? CODE_V3 : CODE_E31;
      tag.exit_code  = ynear[1] ? CODE_V2 : CODE_E12;
    end else if (yneg[0] && ypos[1] && yneg[2]) begin
      ia[0] = 2'd1; ib[0] = 2'd2; ia[1] = 2'd0; ib[1] = 2'd1;
      tag.entry_code = CODE_E23; tag.exit_code = CODE_E12;
    end else if (!yneg[0] && yneg[1] && !yneg[2]) begin
      ia[0] = 2'd0; ib[0] = 2'd1; ia[1] = 2'd1; ib[1] = 2'd2;
      tag.entry_code = ynear[2] ? CODE_V3 : CODE_E12;
      tag.exit_code  = ynear[0] ? CODE_V1 : CODE_E23;
    end else if (yneg[0] && yneg[1] && ypos[2]) begin
      ia[0] = 2'd0; ib[0] = 2'd2; ia[1] = 2'd1; ib[1] = 2'd2;
      tag.entry_code = CODE_E31; tag.exit_code = CODE_E23;
    end else if (!yneg[0] && !yneg[1] && yneg[2]) begin
      ia[0] = 2'd1; ib[0] = 2'd2; ia[1] = 2'd0; ib[1] = 2'd2;
      tag.entry_code = ynear[1] ? CODE_V2 : CODE_E23;
      tag.exit_code  = ynear[0] ? CODE_V1 : CODE_E31;
    end else begin
      tag.hit = 1'b0;
    end
  end

  // A miss is sent on as a degenerate segment at the origin, which yields zeros.
  always_comb begin
    logic [W-1:0] mag;
    for (int s = 0; s < 2; s++) begin
      seg_ax[s] = tag.hit ? vx[ia[s]] : '0;
      seg_az[s] = tag.hit ? vz[ia[s]] : '0;
      seg_bx[s] = tag.hit ? vx[ib[s]] : '0;
      seg_bz[s] = tag.hit ? vz[ib[s]] : '0;
      seg_ay[s] = tag.hit ? vy[ia[s]] : '0;
      seg_den[s] = {seg_ay[s][COORD_BITS-1], seg_ay[s]} -
                   (tag.hit ? {vy[ib[s]][COORD_BITS-1], vy[ib[s]]} : '0);
      mag = seg_den[s][W-1] ? W'(-seg_den[s]) : W'(seg_den[s]);
      seg_degen[s] = !tag.hit || (seg_den[s] == '0) ||
                     ({{EPS_BITS{1'b0}}, mag} < {{W{1'b0}}, plane_epsilon});
    end
  end

endmodule
`default_nettype wire

>>> src/tpc_queue.sv
// Two-entry request queue between the front end and the crossing pipelines.
`default_nettype none
module tpc_queue
  import tpc_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  wire  [WIDTH-1:0] din,
  input  wire              pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] mem [QDEPTH];
  logic             wptr, rptr;
  logic [1:0]       count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign dout  = mem[rptr];
  assign full  = (count == 2'(QDEPTH));
  assign empty = (count == '0);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(QDEPTH)) else $error("queue count above depth");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("pop from empty queue");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd1) |-> (wptr != rptr)) else $error("queue pointers out of step");

endmodule
`default_nettype wire

>>> src/tpc_axis.sv
// Pipelined crossing of one axis: A + Ay*(B-A)/(Ay-By), truncated and saturated.
`default_nettype none
module tpc_axis #(
  parameter int COORD_BITS = 32,
  parameter int TAG_W      = 1
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  input  wire  signed [COORD_BITS-1:0] a,
  input  wire  signed [COORD_BITS-1:0] b,
  input  wire  signed [COORD_BITS-1:0] ay,
  input  wire  signed [COORD_BITS:0]   den,
  input  wire                          degen,
  input  wire  [TAG_W-1:0]             tag_in,
  output logic                         out_valid,
  output logic signed [COORD_BITS-1:0] res,
  output logic [TAG_W-1:0]             tag_out
);

  localparam int W  = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS;

  logic signed [W-1:0] diff;

  // Stage 1: magnitudes and sign of the quotient.
  logic                  s1_v, s1_neg, s1_degen;
  logic [COORD_BITS-1:0] s1_aymag;
  logic [W-1:0]          s1_dmag, s1_denmag;
  logic signed [COORD_BITS-1:0] s1_a;
  logic [TAG_W-1:0]      s1_tag;

  // Stage 2: exact product.
  logic                  s2_v, s2_neg, s2_degen;
  logic [PW-1:0]         s2_prod;
  logic [W-1:0]          s2_denmag;
  logic signed [COORD_BITS-1:0] s2_a;
  logic [TAG_W-1:0]      s2_tag;

  // Divider stages, one quotient bit each.
  logic                  dv    [W+1];
  logic                  dneg  [W+1];
  logic                  ddeg  [W+1];
  logic [W-1:0]          drem  [W+1];
  logic [W-1:0]          dlow  [W+1];
  logic [W-1:0]          dquo  [W+1];
  logic [W-1:0]          dden  [W+1];
  logic signed [COORD_BITS-1:0] da [W+1];
  logic [TAG_W-1:0]      dtag  [W+1];

  logic signed [W:0]     sum;

  assign diff = {b[COORD_BITS-1], b} - {a[COORD_BITS-1], a};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= in_valid;
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_neg    <= ay[COORD_BITS-1] ^ diff[W-1] ^ den[W-1];
    s1_aymag  <= ay[COORD_BITS-1] ? COORD_BITS'(-ay) : COORD_BITS'(ay);
    s1_dmag   <= diff[W-1] ? W'(-diff) : W'(diff);
    s1_denmag <= den[W-1] ? W'(-den) : W'(den);
    s1_a      <= a;
    s1_degen  <= degen;
    s1_tag    <= tag_in;

    // The difference magnitude has one bit above the multiplier width.
    s2_prod   <= PW'(s1_aymag * s1_dmag[COORD_BITS-1:0]) +
                 (s1_dmag[COORD_BITS] ? {s1_aymag, {COORD_BITS{1'b0}}} : '0);
    s2_neg    <= s1_neg;
    s2_denmag <= s1_denmag;
    s2_a      <= s1_a;
    s2_degen  <= s1_degen;
    s2_tag    <= s1_tag;
  end

  // The quotient is at most |B-A|, so the upper product bits start below the divisor.
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    drem[0] <= W'(s2_prod[PW-1:W]);
    dlow[0] <= s2_prod[W-1:0];
    dquo[0] <= '0;
    dden[0] <= s2_denmag;
    dneg[0] <= s2_neg;
    ddeg[0] <= s2_degen;
    da[0]   <= s2_a;
    dtag[0] <= s2_tag;
  end

  for (genvar k = 0; k < W; k++) begin : g_div
    logic [W:0] trial;
    logic       qbit;

    assign trial = {drem[k], dlow[k][W-1-k]};
    assign qbit  = (trial >= {1'b0, dden[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      drem[k+1] <= qbit ? W'(trial - {1'b0, dden[k]}) : W'(trial);
      dquo[k+1] <= {dquo[k][W-2:0], qbit};
      dlow[k+1] <= dlow[k];
      dden[k+1] <= dden[k];
      dneg[k+1] <= dneg[k];
      ddeg[k+1] <= ddeg[k];
      da[k+1]   <= da[k];
      dtag[k+1] <= dtag[k];
    end
  end

  assign sum = dneg[W] ? ({{2{da[W][COORD_BITS-1]}}, da[W]} - {1'b0, dquo[W]})
                       : ({{2{da[W][COORD_BITS-1]}}, da[W]} + {1'b0, dquo[W]});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv[W];
    end
  end

  always_ff @(posedge clk) begin
    tag_out <= dtag[W];
    if (ddeg[W]) begin
      res <= da[W];
    end else if (sum[W:COORD_BITS-1] != {(W-COORD_BITS+2){sum[W]}}) begin
      res <= sum[W] ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
    end else begin
      res <= sum[COORD_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

>>> src/tpc_back.sv
// Back end: four crossing pipelines for the entry and exit points.
`default_nettype none
module tpc_back
  import tpc_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  input  tpc_tag_t                     tag,
  input  wire  signed [COORD_BITS-1:0] seg_ax [2],
  input  wire  signed [COORD_BITS-1:0] seg_az [2],
  input  wire  signed [COORD_BITS-1:0] seg_bx [2],
  input  wire  signed [COORD_BITS-1:0] seg_bz [2],
  input  wire  signed [COORD_BITS-1:0] seg_ay [2],
  input  wire  signed [COORD_BITS:0]   seg_den [2],
  input  wire                          seg_degen [2],
  output logic                         done,
  output logic                         hit,
  output logic signed [COORD_BITS-1:0] entry_x,
  output logic signed [COORD_BITS-1:0] entry_z,
  output logic signed [COORD_BITS-1:0] exit_x,
  output logic signed [COORD_BITS-1:0] exit_z,
  output logic [2:0]                   entry_code,
  output logic [2:0]                   exit_code
);

  tpc_tag_t tag_q;
  logic     v_ez, v_xx, v_xz;

  tpc_axis #(.COORD_BITS(COORD_BITS), .TAG_W($bits(tpc_tag_t))) u_entry_x (
    .clk, .rst, .in_valid,
    .a(seg_ax[0]), .b(seg_bx[0]), .ay(seg_ay[0]), .den(seg_den[0]),
    .degen(seg_degen[0]), .tag_in(tag),
    .out_valid(done), .res(entry_x), .tag_out(tag_q)
  );

  tpc_axis #(.COORD_BITS(COORD_BITS), .TAG_W(1)) u_entry_z (
    .clk, .rst, .in_valid,
    .a(seg_az[0]), .b(seg_bz[0]), .ay(seg_ay[0]), .den(seg_den[0]),
    .degen(seg_degen[0]), .tag_in(1'b0),
    .out_valid(v_ez), .res(entry_z), .tag_out()
  );

  tpc_axis #(.COORD_BITS(COORD_BITS), .TAG_W(1)) u_exit_x (
    .clk, .rst, .in_valid,
    .a(seg_ax[1]), .b(seg_bx[1]), .ay(seg_ay[1]), .den(seg_den[1]),
    .degen(seg_degen[1]), .tag_in(1'b0),
    .out_valid(v_xx), .res(exit_x), .tag_out()
  );

  tpc_axis #(.COORD_BITS(COORD_BITS), .TAG_W(1)) u_exit_z (
    .clk, .rst, .in_valid,
    .a(seg_az[1]), .b(seg_bz[1]), .ay(seg_ay[1]), .den(seg_den[1]),
    .degen(seg_degen[1]), .tag_in(1'b0),
    .out_valid(v_xz), .res(exit_z), .tag_out()
  );

  assign hit        = tag_q.hit;
  assign entry_code = tag_q.entry_code;
  assign exit_code  = tag_q.exit_code;

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (done == v_ez) && (done == v_xx) && (done == v_xz))
    else $error("crossing lanes out of step");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (entry_x == '0 && exit_z == '0 && entry_code == CODE_NONE))
    else $error("miss with nonzero result");
  a_hit_codes: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (entry_code != CODE_NONE && exit_code != CODE_NONE))
    else $error("hit without codes");

endmodule
`default_nettype wire

>>> src/triangle_plane_crossing_core.sv
// Top level of the triangle / y=0 plane crossing core.
//
//  channel   signals                          handshake
//  request   start, busy, v1_x .. v3_z        taken when start=1 and busy=0
//  result    done, hit, entry_*, exit_*       done high one cycle, no back-pressure
//  config    eps_we, eps_wdata                written when eps_we=1
//
// One request enters per cycle while busy is low; the result passes through the queue and then
// the four crossing pipelines, whose dividers resolve one quotient bit per stage.
// Reset is synchronous; it clears the queue and pipeline valids and sets the tolerance to 1.
// The back end drains the queue every cycle, so busy only rises if the queue is full.
`default_nettype none
module triangle_plane_crossing_core
  import tpc_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          eps_we,
  input  wire  [EPS_BITS-1:0]          eps_wdata,
  input  wire                          start,
  output logic                         busy,
  input  wire  signed [COORD_BITS-1:0] v1_x,
  input  wire  signed [COORD_BITS-1:0] v1_y,
  input  wire  signed [COORD_BITS-1:0] v1_z,
  input  wire  signed [COORD_BITS-1:0] v2_x,
  input  wire  signed [COORD_BITS-1:0] v2_y,
  input  wire  signed [COORD_BITS-1:0] v2_z,
  input  wire  signed [COORD_BITS-1:0] v3_x,
  input  wire  signed [COORD_BITS-1:0] v3_y,
  input  wire  signed [COORD_BITS-1:0] v3_z,
  output logic                         done,
  output logic                         hit,
  output logic signed [COORD_BITS-1:0] entry_x,
  output logic signed [COORD_BITS-1:0] entry_z,
  output logic signed [COORD_BITS-1:0] exit_x,
  output logic signed [COORD_BITS-1:0] exit_z,
  output logic [2:0]                   entry_code,
  output logic [2:0]                   exit_code
);

  localparam int CB    = COORD_BITS;
  localparam int SEG_W = 5 * CB + (CB + 1) + 1;
  localparam int TAG_W = $bits(tpc_tag_t);
  localparam int QW    = 2 * SEG_W + TAG_W;

  tpc_tag_t f_tag, b_tag;
  logic signed [CB-1:0] f_ax [2], f_az [2], f_bx [2], f_bz [2], f_ay [2];
  logic signed [CB:0]   f_den [2];
  logic                 f_degen [2];
  logic signed [CB-1:0] b_ax [2], b_az [2], b_bx [2], b_bz [2], b_ay [2];
  logic signed [CB:0]   b_den [2];
  logic                 b_degen [2];

  logic [QW-1:0] q_din, q_dout;
  logic          q_full, q_empty, push, pop;

  tpc_front #(.COORD_BITS(CB)) u_front (
    .clk, .rst, .eps_we, .eps_wdata,
    .v1_x, .v1_y, .v1_z, .v2_x, .v2_y, .v2_z, .v3_x, .v3_y, .v3_z,
    .tag(f_tag), .seg_ax(f_ax), .seg_az(f_az), .seg_bx(f_bx), .seg_bz(f_bz),
    .seg_ay(f_ay), .seg_den(f_den), .seg_degen(f_degen)
  );

  assign q_din = {f_tag,
                  f_ax[0], f_az[0], f_bx[0], f_bz[0], f_ay[0], f_den[0], f_degen[0],
                  f_ax[1], f_az[1], f_bx[1], f_bz[1], f_ay[1], f_den[1], f_degen[1]};

  assign busy = q_full;
  assign push = start && !q_full;
  assign pop  = !q_empty;

  tpc_queue #(.WIDTH(QW)) u_queue (
    .clk, .rst, .push, .din(q_din), .pop, .dout(q_dout),
    .full(q_full), .empty(q_empty)
  );

  assign {b_tag,
          b_ax[0], b_az[0], b_bx[0], b_bz[0], b_ay[0], b_den[0], b_degen[0],
          b_ax[1], b_az[1], b_bx[1], b_bz[1], b_ay[1], b_den[1], b_degen[1]} = q_dout;

  tpc_back #(.COORD_BITS(CB)) u_back (
    .clk, .rst, .in_valid(pop), .tag(b_tag),
    .seg_ax(b_ax), .seg_az(b_az), .seg_bx(b_bx), .seg_bz(b_bz),
    .seg_ay(b_ay), .seg_den(b_den), .seg_degen(b_degen),
    .done, .hit, .entry_x, .entry_z, .exit_x, .exit_z, .entry_code, .exit_code
  );

endmodule
`default_nettype wire

>>> tb/sv/tpc_checker.sv
// Checker for the crossing core: predicts each request's result and compares it with the result port.
module tpc_checker
  import tpc_pkg::*;
(
  input  wire               clk,
  input  wire               rst,
  input  wire               eps_we,
  input  wire [15:0]        eps_wdata,
  input  wire               start,
  input  wire               busy,
  input  wire signed [31:0] v1_x, v1_y, v1_z,
  input  wire signed [31:0] v2_x, v2_y, v2_z,
  input  wire signed [31:0] v3_x, v3_y, v3_z,
  input  wire               done,
  input  wire               hit,
  input  wire signed [31:0] entry_x, entry_z, exit_x, exit_z,
  input  wire [2:0]         entry_code, exit_code,
  output int                fail_count,
  output int                pending,
  output int                result_count,
  output int                hit_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic               hit;
    logic signed [31:0] ex, ez, xx, xz;
    code_t              ec, xc;
  } crossing_t;

  crossing_t expected_q[$];
  logic [15:0] tol;

  // One axis of A + Ay*(B-A)/(Ay-By), quotient truncated toward zero, sum saturated.
  function automatic logic signed [31:0] axis_point(longint ay, longint den, longint a, longint b);
    longint diff, sum;
    logic [127:0] prod, quo;
    logic neg;
    diff = b - a;
    neg = ((ay < 0) != (diff < 0)) != (den < 0);
    prod = 128'(ay < 0 ? -ay : ay) * 128'(diff < 0 ? -diff : diff);
    quo = prod / 128'(den < 0 ? -den : den);
    if (quo > (128'd1 << 62)) quo = 128'd1 << 62;
    if (quo == 0) neg = 1'b0;
    sum = neg ? a - longint'(quo[63:0]) : a + longint'(quo[63:0]);
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return sum[31:0];
  endfunction

  function automatic void edge_point(longint ax, longint ay, longint az, longint bx, longint by,
                                     longint bz, output logic signed [31:0] px,
                                     output logic signed [31:0] pz);
    longint den;
    den = ay - by;
    if (den == 0 || (den < 0 ? -den : den) < longint'(tol)) begin
      px = ax[31:0];
      pz = az[31:0];
    end else begin
      px = axis_point(ay, den, ax, bx);
      pz = axis_point(ay, den, az, bz);
    end
  endfunction

  function automatic crossing_t predict_crossing();
    crossing_t r;
    longint x1, y1, z1, x2, y2, z2, x3, y3, z3, e;
    x1 = v1_x; y1 = v1_y; z1 = v1_z;
    x2 = v2_x; y2 = v2_y; z2 = v2_z;
    x3 = v3_x; y3 = v3_y; z3 = v3_z;
    e = longint'(tol);
    r.hit = 1'b1;
    r.ex = 0; r.ez = 0; r.xx = 0; r.xz = 0;
    r.ec = CODE_NONE; r.xc = CODE_NONE;
    if (y1 > 0 && y2 < 0 && y3 < 0) begin
      edge_point(x1, y1, z1, x2, y2, z2, r.ex, r.ez);
      edge_point(x1, y1, z1, x3, y3, z3, r.xx, r.xz);
      r.ec = CODE_E12; r.xc = CODE_E31;
    end else if (y1 < 0 && y2 >= 0 && y3 >= 0) begin
      edge_point(x1, y1, z1, x3, y3, z3, r.ex, r.ez);
      edge_point(x1, y1, z1, x2, y2, z2, r.xx, r.xz);
      r.ec = CODE_E31; r.xc = CODE_E12;
      if (y2 < e) r.xc = CODE_V2;
      if (y3 < e) r.ec = CODE_V3;
    end else if (y1 < 0 && y2 > 0 && y3 < 0) begin
      edge_point(x2, y2, z2, x3, y3, z3, r.ex, r.ez);
      edge_point(x1, y1, z1, x2, y2, z2, r.xx, r.xz);
      r.ec = CODE_E23; r.xc = CODE_E12;
    end else if (y1 >= 0 && y2 < 0 && y3 >= 0) begin
      edge_point(x1, y1, z1, x2, y2, z2, r.ex, r.ez);
      edge_point(x2, y2, z2, x3, y3, z3, r.xx, r.xz);
      r.ec = CODE_E12; r.xc = CODE_E23;
      if (y1 < e) r.xc = CODE_V1;
      if (y3 < e) r.ec = CODE_V3;
    end else if (y1 < 0 && y2 < 0 && y3 > 0) begin
      edge_point(x1, y1, z1, x3, y3, z3, r.ex, r.ez);
      edge_point(x2, y2, z2, x3, y3, z3, r.xx, r.xz);
      r.ec = CODE_E31; r.xc = CODE_E23;
    end else if (y1 >= 0 && y2 >= 0 && y3 < 0) begin
      edge_point(x2, y2, z2, x3, y3, z3, r.ex, r.ez);
      edge_point(x1, y1, z1, x3, y3, z3, r.xx, r.xz);
      r.ec = CODE_E23; r.xc = CODE_E31;
      if (y1 < e) r.xc = CODE_V1;
      if (y2 < e) r.ec = CODE_V2;
    end else begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    crossing_t want;
    if (rst) begin
      tol <= EPS_RESET;
      expected_q.delete();
      fail_count <= 0;
      result_count <= 0;
      hit_count <= 0;
    end else begin
      if (start && !busy) expected_q.insert(expected_q.size(), predict_crossing());
      if (eps_we) tol <= eps_wdata;
      if (done) begin
        result_count <= result_count + 1;
        if (hit) hit_count <= hit_count + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: result with no request waiting", $time);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (hit !== want.hit || entry_x !== want.ex || entry_z !== want.ez ||
              exit_x !== want.xx || exit_z !== want.xz ||
              entry_code !== want.ec || exit_code !== want.xc) begin
            $display("%0t: mismatch expected hit=%0b en=(%0d,%0d) ex=(%0d,%0d) codes=%0d/%0d",
                     $time, want.hit, want.ex, want.ez, want.xx, want.xz, want.ec, want.xc);
            $display("%0t:          actual hit=%0b en=(%0d,%0d) ex=(%0d,%0d) codes=%0d/%0d",
                     $time, hit, entry_x, entry_z, exit_x, exit_z, entry_code, exit_code);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign pending = expected_q.size();
endmodule

>>> tb/sv/tb_triangle_plane_crossing_core.sv
// Testbench top for the crossing core: drives triangles and tolerance settings, gives the verdict.
module tb_triangle_plane_crossing_core
  import tpc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic eps_we = 1'b0;
  logic [15:0] eps_wdata = '0;
  logic start = 1'b0;
  logic signed [31:0] v1_x = 0, v1_y = 0, v1_z = 0, v2_x = 0, v2_y = 0, v2_z = 0;
  logic signed [31:0] v3_x = 0, v3_y = 0, v3_z = 0;
  wire busy, done, hit;
  wire signed [31:0] entry_x, entry_z, exit_x, exit_z;
  wire [2:0] entry_code, exit_code;
  int fail_count, pending, result_count, hit_count;
  int cycles = 0;
  logic [15:0] tol;
  bit idle_on = 1'b1;

  always #1 clk = ~clk;

  triangle_plane_crossing_core dut (
    .clk, .rst, .eps_we, .eps_wdata, .start, .busy,
    .v1_x, .v1_y, .v1_z, .v2_x, .v2_y, .v2_z, .v3_x, .v3_y, .v3_z,
    .done, .hit, .entry_x, .entry_z, .exit_x, .exit_z, .entry_code, .exit_code
  );

  tpc_checker chk (
    .clk, .rst, .eps_we, .eps_wdata, .start, .busy,
    .v1_x, .v1_y, .v1_z, .v2_x, .v2_y, .v2_z, .v3_x, .v3_y, .v3_z,
    .done, .hit, .entry_x, .entry_z, .exit_x, .exit_z, .entry_code, .exit_code,
    .fail_count, .pending, .result_count, .hit_count
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Busy only changes at a rising edge, so its value at the falling edge holds for the next one.
  task automatic send_request(logic signed [31:0] ax, ay, az, bx, by, bz, cx, cy, cz);
    @(negedge clk);
    v1_x = ax; v1_y = ay; v1_z = az;
    v2_x = bx; v2_y = by; v2_z = bz;
    v3_x = cx; v3_y = cy; v3_z = cz;
    start = 1'b1;
    while (busy) @(negedge clk);
    @(posedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(1, 7) - 1) @(negedge clk);
    end
  endtask

  task automatic drain_and_set(logic [15:0] value);
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    eps_wdata = value;
    eps_we = 1'b1;
    tol = value;
    @(negedge clk);
    eps_we = 1'b0;
  endtask

  // Heights cluster around the plane and the tolerance so the near-vertex codes fire.
  function automatic logic signed [31:0] pick_y();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = 32'(tol);
      2: v = 32'(tol) - 1;
      3: v = -1;
      4, 5: begin
        v = 32'($urandom_range(0, 2 * tol + 4));
        if ($urandom_range(0, 1)) v = -v;
      end
      6: v = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] pick_xz();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'($urandom_range(0, 1000)) - 500;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random();
    send_request(pick_xz(), pick_y(), pick_xz(), pick_xz(), pick_y(), pick_xz(),
                 pick_xz(), pick_y(), pick_xz());
  endtask

  localparam logic signed [31:0] MX = 32'sh7fffffff;
  localparam logic signed [31:0] MN = 32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sh00010000;

  initial begin
    tol = EPS_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: each sign case, near-plane vertices, degenerate edges, extremes, no hit.
    send_request(0, ONE, 0, ONE, -ONE, ONE, -ONE, -ONE, -ONE);
    send_request(0, -ONE, 0, ONE, 0, ONE, -ONE, 0, -ONE);
    send_request(0, -ONE, 0, ONE, ONE, ONE, -ONE, ONE, -ONE);
    send_request(5, -ONE, 7, 9, ONE, 11, 13, -ONE, 15);
    send_request(0, 0, 0, ONE, -ONE, ONE, -ONE, 0, -ONE);
    send_request(1, ONE, 2, 3, -ONE, 4, 5, ONE, 6);
    send_request(0, -ONE, 0, ONE, -ONE, ONE, -ONE, ONE, -ONE);
    send_request(0, 0, 0, 0, 0, ONE, -ONE, -ONE, -ONE);
    send_request(1, ONE, 1, 2, ONE, 2, 3, -ONE, 3);
    send_request(MX, MX, MN, MN, MN, MX, MX, MN, MN);
    send_request(MN, MN, MX, MX, MX, MN, MN, MX, MX);
    send_request(MX, MX, MX, MN, -1, MN, MX, -1, MN);
    send_request(MN, 1, MN, MX, -1, MX, MN, -1, MX);
    send_request(0, ONE, 0, 0, ONE, 0, 0, ONE, 0);
    send_request(0, -ONE, 0, 0, -ONE, 0, 0, -ONE, 0);
    send_request(-1, -1, -1, -1, 0, -1, -1, 0, -1);

    drain_and_set(16'd0);
    send_request(3, 0, 4, 5, -1, 6, 7, 0, 8);
    send_request(3, -1, 4, 5, 0, 6, 7, 0, 8);
    send_request(3, 1, 4, 5, 1, 6, 7, -1, 8);
    send_request(3, 0, 4, 5, 0, 6, 7, -1, 8);
    repeat (150) send_random();

    drain_and_set(16'hffff);
    send_request(0, 16'hfffe, 0, ONE, -1, ONE, 0, 16'hffff, 0);
    send_request(0, -ONE, 0, ONE, ONE, ONE, 9, -1, 9);
    send_request(MX, 100, MX, MN, -100, MN, MX, 200, MN);
    repeat (150) send_random();

    drain_and_set(16'($urandom_range(2, 65534)));
    repeat (150) send_random();

    drain_and_set(EPS_RESET);
    repeat (150) send_random();

    drain_and_set(16'($urandom_range(0, 255)));
    idle_on = 1'b0;
    repeat (150) send_random();

    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Checked %0d results (%0d hits) across six tolerance settings incl. 0 and 65535.",
             result_count, hit_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d failures", fail_count);
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

>>> files.f
src/tpc_pkg.sv
src/tpc_front.sv
src/tpc_queue.sv
src/tpc_axis.sv
src/tpc_back.sv
src/triangle_plane_crossing_core.sv
tb/sv/tpc_checker.sv
tb/sv/tb_triangle_plane_crossing_core.sv
